// ===== rtl/tccw_pkg.sv =====
// shared constants, types and helpers for the text console cursor writer
package tccw_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  // field widths
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int ADDR_W   = 11;
  localparam int CELL_W   = 16;
  localparam int TAB_W    = 5;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 3;

  // remainder unit: one quotient bit per step over the column value
  localparam int DIV_STEPS = COL_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // command opcodes
  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GOTO  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // control characters
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAB        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_END    = 3'd4;

  // input item
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [7:0] goto_col;
    logic [7:0] goto_row;
    logic       to_screen;
  } in_item_t;

  // result item
  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_addr;
    logic [CELL_W-1:0] write_value;
    logic              scroll_up;
    logic              clear_all;
    logic [CELL_W-1:0] fill_value;
    logic [ADDR_W-1:0] cursor_addr;
    logic              cursor_load;
    logic              target_screen;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_tab;
  } dp_status_t;

  // linear cell index, kept to the address width
  function automatic logic [ADDR_W-1:0] lin_addr(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
    logic [ADDR_W+1:0] sum;
    sum = (ADDR_W+2)'(row) * (ADDR_W+2)'(COLUMNS) + (ADDR_W+2)'(col);
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/tccw_if.sv =====
// handshake channels for commands and results
interface tccw_cmd_if;
  import tccw_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_code;
  logic [7:0] goto_col;
  logic [7:0] goto_row;
  logic       to_screen;

  modport source(output valid, opcode, char_code, goto_col, goto_row, to_screen,
                 input ready);
  modport sink(input valid, opcode, char_code, goto_col, goto_row, to_screen,
               output ready);
endinterface

interface tccw_res_if;
  import tccw_pkg::*;
  logic              valid;
  logic              ready;
  logic              write_valid;
  logic [ADDR_W-1:0] write_addr;
  logic [CELL_W-1:0] write_value;
  logic              scroll_up;
  logic              clear_all;
  logic [CELL_W-1:0] fill_value;
  logic [ADDR_W-1:0] cursor_addr;
  logic              cursor_load;
  logic              target_screen;

  modport source(output valid, write_valid, write_addr, write_value, scroll_up,
                 clear_all, fill_value, cursor_addr, cursor_load, target_screen,
                 input ready);
  modport sink(input valid, write_valid, write_addr, write_value, scroll_up,
               clear_all, fill_value, cursor_addr, cursor_load, target_screen,
               output ready);
endinterface

// ===== rtl/tccw_ctrl.sv =====
// sequencing state machine for the cursor writer
module tccw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tccw_pkg::dp_status_t status,
  output tccw_pkg::ctrl_cmd_t  cmd
);
  import tccw_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EXEC
  } state_t;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  state_t           state;
  logic [CNT_W-1:0] cnt;

  // command decode
  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd.start    = in_valid && in_ready;
    cmd.div_step = (state == S_DIV);
    cmd.commit   = (state == S_EXEC) && (!out_valid || out_ready);
  end

  // state, step count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            cnt   <= '0;
            state <= status.in_is_tab ? S_DIV : S_EXEC;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.commit) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a result is only written into a free or draining output register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit over an untaken result");

  // a new result appears only after a commit
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result valid without commit");

  // the remainder unit runs exactly its step count
  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == DIV_LAST) |=> state == S_EXEC)
    else $error("remainder steps overran");

  // an accepted command leaves idle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !in_ready)
    else $error("still idle after a transfer");
`endif

endmodule

// ===== rtl/tccw_dp.sv =====
// cursor state, registers, remainder unit and result register
module tccw_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tccw_pkg::CFG_W-1:0]         cfg_data,
  input  tccw_pkg::in_item_t                 item_in,
  input  tccw_pkg::ctrl_cmd_t                cmd,
  output tccw_pkg::dp_status_t               status,
  output tccw_pkg::out_item_t                result
);
  import tccw_pkg::*;

  // configuration registers
  logic [3:0]       background_colour;
  logic [3:0]       text_colour;
  logic [TAB_W-1:0] tab_width;
  logic [4:0]       cursor_start_line;
  logic [4:0]       cursor_end_line;

  // cursor and captured command
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  in_item_t         item;

  // remainder unit
  logic [TAB_W-1:0] rem;
  logic [COL_W-1:0] dividend;
  logic [TAB_W-1:0] tw1;
  logic [TAB_W:0]   trial;
  logic [TAB_W-1:0] rem_next;

  // next cursor and result
  logic [COL_W:0]   col_next;
  logic [ROW_W:0]   row_next;
  logic [COL_W-1:0] col_final;
  logic [ROW_W-1:0] row_final;
  out_item_t        result_next;
  logic [CELL_W-1:0] attr;

  assign status.in_is_tab = (opcode_t'(item_in.opcode) == OP_PUT) &&
                            (item_in.char_code == CH_HT);

  assign tw1  = (tab_width == '0) ? TAB_W'(1) : tab_width;
  assign attr = {background_colour, text_colour, 8'h00};

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      background_colour <= 4'd0;
      text_colour       <= 4'd7;
      tab_width         <= 5'd4;
      cursor_start_line <= 5'd14;
      cursor_end_line   <= 5'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BACKGROUND: background_colour <= cfg_data[3:0];
        REG_TEXT:       text_colour       <= cfg_data[3:0];
        REG_TAB:        tab_width         <= cfg_data;
        REG_CUR_START:  cursor_start_line <= cfg_data;
        REG_CUR_END:    cursor_end_line   <= cfg_data;
        default: ;
      endcase
    end
  end

  // one restoring step of column modulo tab width
  always_comb begin
    trial = {rem, dividend[COL_W-1]};
    if (trial >= {1'b0, tw1}) begin
      rem_next = TAB_W'(trial - {1'b0, tw1});
    end else begin
      rem_next = trial[TAB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item     <= item_in;
      rem      <= '0;
      dividend <= cursor_col;
    end else if (cmd.div_step) begin
      rem      <= rem_next;
      dividend <= {dividend[COL_W-2:0], 1'b0};
    end
  end

  // command effect on the cursor and the result fields
  always_comb begin
    col_next    = {1'b0, cursor_col};
    row_next    = {1'b0, cursor_row};
    result_next = '0;
    result_next.target_screen = item.to_screen;
    case (opcode_t'(item.opcode))
      OP_PUT: begin
        if (item.char_code == CH_BS) begin
          if (cursor_col != '0) begin
            col_next = col_next - 1'b1;
          end
        end else if (item.char_code == CH_HT) begin
          // next stop: column less remainder plus width
          col_next = col_next - (COL_W+1)'(rem) + (COL_W+1)'(tw1);
        end else if (item.char_code == CH_LF) begin
          col_next = '0;
          row_next = row_next + 1'b1;
        end else if (item.char_code == CH_CR) begin
          col_next = '0;
        end else begin
          result_next.write_valid = 1'b1;
          result_next.write_addr  = lin_addr(cursor_col, cursor_row);
          result_next.write_value = attr | CELL_W'(item.char_code);
          col_next = col_next + 1'b1;
        end
        // line end wrap
        if (col_next >= (COL_W+1)'(COLUMNS)) begin
          col_next = '0;
          row_next = row_next + 1'b1;
        end
        // past the last row: clamp, scroll unless both cursor lines are zero
        if (row_next >= (ROW_W+1)'(ROWS)) begin
          row_next = (ROW_W+1)'(ROWS - 1);
          if (!(cursor_start_line == '0 && cursor_end_line == '0)) begin
            result_next.scroll_up  = 1'b1;
            result_next.fill_value = attr;
          end
        end
        result_next.cursor_load = item.to_screen;
      end
      OP_GOTO: begin
        if (item.goto_col <= 8'(COLUMNS - 1) && item.goto_row <= 8'(ROWS - 1)) begin
          col_next = (COL_W+1)'(item.goto_col);
          row_next = (ROW_W+1)'(item.goto_row);
          result_next.cursor_load = item.to_screen;
        end
      end
      OP_CLEAR: begin
        result_next.clear_all   = 1'b1;
        result_next.fill_value  = attr | CELL_W'(item.char_code);
        col_next = '0;
        row_next = '0;
        result_next.cursor_load = item.to_screen;
      end
      default: ;
    endcase
    col_final = col_next[COL_W-1:0];
    row_final = row_next[ROW_W-1:0];
    result_next.cursor_addr = lin_addr(col_final, row_final);
  end

  // cursor update
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (cmd.commit) begin
      cursor_col <= col_final;
      cursor_row <= row_final;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/text_console_cursor_writer_unit.sv =====
// top level of the text console cursor writer
// a tab put goes from idle through the remainder steps to execute, others go
// straight there; the bit-serial remainder unit gives one quotient bit per cycle
// over the 7-bit column; a command is taken only in idle, after the last commits
// a result waits in the output register while the next command is taken
// reset: cursor home, registers to defaults, output register empty
module text_console_cursor_writer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tccw_pkg::CFG_W-1:0]     cfg_data,
  tccw_cmd_if.sink                       cmd,
  tccw_res_if.source                     res
);
  import tccw_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;
  in_item_t   item_in;
  out_item_t  result;

  // command payload into the datapath
  always_comb begin
    item_in.opcode    = cmd.opcode;
    item_in.char_code = cmd.char_code;
    item_in.goto_col  = cmd.goto_col;
    item_in.goto_row  = cmd.goto_row;
    item_in.to_screen = cmd.to_screen;
  end

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .cmd       (ctrl)
  );

  tccw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_in   (item_in),
    .cmd       (ctrl),
    .status    (status),
    .result    (result)
  );

  // result payload out
  always_comb begin
    res.write_valid   = result.write_valid;
    res.write_addr    = result.write_addr;
    res.write_value   = result.write_value;
    res.scroll_up     = result.scroll_up;
    res.clear_all     = result.clear_all;
    res.fill_value    = result.fill_value;
    res.cursor_addr   = result.cursor_addr;
    res.cursor_load   = result.cursor_load;
    res.target_screen = result.target_screen;
  end

endmodule
